// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition does not hold");

// When the trigger holds, the outcome must hold at the next clock edge.
`define ASSERT_NEXT(label, clk, rst, trig, outcome) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (outcome)) \
      else $error("assertion failed: expected outcome missing one cycle later");

`endif

// ===== hw/rtl/urf_pkg.sv =====
// Package with the codes and register constants of the UART receive FIFO block.
package urf_pkg;

   // Item kinds carried on req_func; the fourth code is a no-operation.
   typedef enum logic [1:0] {
      FUNC_READ    = 2'd0,
      FUNC_WRITE   = 2'd1,
      FUNC_RECEIVE = 2'd2
   } func_type;

   // Bus register offsets.
   localparam logic [7:0] OFFSET_DATA    = 8'd0;
   localparam logic [7:0] OFFSET_STATUS  = 8'd1;
   localparam logic [7:0] OFFSET_CONTROL = 8'd2;

   // Status register bits.
   localparam logic [7:0] SR_RX_READY = 8'h01;
   localparam logic [7:0] SR_TX_EMPTY = 8'h02;
   localparam logic [7:0] SR_OVERRUN  = 8'h04;

   // Control register bits.
   localparam logic [7:0] CR_RX_IE = 8'h01;
   localparam logic [7:0] CR_TX_IE = 8'h02;

endpackage

// ===== hw/rtl/uart_rx_fifo_registers.sv =====
// Top level of the memory-mapped UART register block with its receive FIFO.
// The result of a beat accepted at one clock edge is on the rsp_ ports in the next cycle.
// Throughput: one beat per cycle outside reset; the state and the FIFO RAM update at the accepting edge.
// The result is shown for exactly one cycle under rsp_valid; the receiver cannot stall it.
// Reset is synchronous and active high; busy is high while reset is held.
// Reset clears the pointers, fill count, overrun flag and control register; the FIFO RAM is not cleared.
module uart_rx_fifo_registers
   import urf_pkg::*;
#(
   parameter int FIFO_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_func,
   input  logic [7:0] req_offset,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   output logic [7:0] rsp_read_data,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_irq
);

   // Pointer width covers the slots; the fill count must also hold the depth itself.
   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(FIFO_DEPTH);

   // Control state.
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             overrun_ff, overrun_in;
   logic [7:0]       control_ff, control_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Result registers.
   logic       pop_ff, pop_in;
   logic [7:0] rd_other_ff, rd_other_in;
   logic       tx_valid_ff, tx_valid_in;
   logic [7:0] tx_byte_ff, tx_byte_in;
   logic       irq_ff, irq_in;

   logic       accept;
   logic       fifo_empty;
   logic       fifo_full;
   logic       push;
   logic [7:0] ram_rd_data;

   // The block is ready in every cycle except while reset is held.
   assign busy   = reset;
   assign accept = start && !busy;

   assign fifo_empty = (count_ff == '0);
   assign fifo_full  = (count_ff == FULL_CNT);

   // The RAM always reads the oldest slot. A byte written at one edge is visible
   // to the read at the next edge, which is the earliest a pop can ask for it.
   urf_ram #(
      .WIDTH(8),
      .DEPTH(FIFO_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_rx_byte),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // Decode of the beat and the next state of the register file.
   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      overrun_in   = overrun_ff;
      control_in   = control_ff;
      rsp_valid_in = accept;
      push         = 1'b0;
      pop_in       = 1'b0;
      rd_other_in  = '0;
      tx_valid_in  = 1'b0;
      tx_byte_in   = '0;

      if (accept) begin
         case (req_func)
            FUNC_READ: begin
               unique case (req_offset)
                  OFFSET_DATA: begin
                     // A read of an empty FIFO returns zero and changes nothing.
                     if (!fifo_empty) begin
                        pop_in    = 1'b1;
                        rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
                        count_in  = count_ff - 1'b1;
                     end
                  end
                  OFFSET_STATUS: begin
                     rd_other_in = SR_TX_EMPTY
                                 | (fifo_empty ? 8'h00 : SR_RX_READY)
                                 | (overrun_ff ? SR_OVERRUN : 8'h00);
                  end
                  OFFSET_CONTROL: begin
                     rd_other_in = control_ff;
                  end
                  default: begin
                  end
               endcase
            end
            FUNC_WRITE: begin
               unique case (req_offset)
                  OFFSET_DATA: begin
                     tx_valid_in = 1'b1;
                     tx_byte_in  = req_write_data;
                  end
                  OFFSET_STATUS: begin
                     // Any write of the status register clears the overrun flag.
                     overrun_in = 1'b0;
                  end
                  OFFSET_CONTROL: begin
                     control_in = req_write_data;
                  end
                  default: begin
                  end
               endcase
            end
            FUNC_RECEIVE: begin
               // A byte arriving at a full FIFO is dropped and flags an overrun.
               if (fifo_full) begin
                  overrun_in = 1'b1;
               end else begin
                  push      = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
                  count_in  = count_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // Interrupt level as it stands after this beat.
      irq_in = (((control_in & CR_RX_IE) != 8'h00) && (count_in != '0))
             || ((control_in & CR_TX_IE) != 8'h00);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         overrun_ff   <= 1'b0;
         control_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         overrun_ff   <= overrun_in;
         control_ff   <= control_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset: it is only looked at under rsp_valid.
   always_ff @(posedge clock) begin
      pop_ff      <= pop_in;
      rd_other_ff <= rd_other_in;
      tx_valid_ff <= tx_valid_in;
      tx_byte_ff  <= tx_byte_in;
      irq_ff      <= irq_in;
   end

   // A popped byte comes straight from the registered RAM output.
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = pop_ff ? ram_rd_data : rd_other_ff;
   assign rsp_tx_valid  = tx_valid_ff;
   assign rsp_tx_byte   = tx_byte_ff;
   assign rsp_irq       = irq_ff;

endmodule

// ===== hw/rtl/urf_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module urf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/urf_checker.sv =====
// Port-level checker for the UART receive FIFO block, with its bind statement.
`include "assert_macros.svh"

module urf_checker
   import urf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_func,
   input logic [7:0] req_offset,
   input logic [7:0] req_write_data,
   input logic [7:0] req_rx_byte,
   input logic       rsp_valid,
   input logic [7:0] rsp_read_data,
   input logic       rsp_tx_valid,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_irq
);

   logic       accept;
   logic       data_write;
   logic       no_read;
   logic       tx_ie_write;
   logic       tx_byte_sent;
   logic [7:0] write_data_ff;

   assign accept      = start && !busy;
   assign data_write  = accept && (req_func == FUNC_WRITE) && (req_offset == OFFSET_DATA);
   assign no_read     = accept && (req_func != FUNC_READ);
   assign tx_ie_write = accept && (req_func == FUNC_WRITE) && (req_offset == OFFSET_CONTROL)
                        && req_write_data[1];

   // The written byte of the beat taken at the previous edge.
   always_ff @(posedge clock) begin
      write_data_ff <= req_write_data;
   end

   assign tx_byte_sent = rsp_tx_valid && (rsp_tx_byte == write_data_ff);

   `ASSERT_NEXT(a_one_result_per_beat, clock, reset, accept, rsp_valid)
   `ASSERT_ALWAYS(a_tx_only_in_result, clock, reset, !rsp_tx_valid || rsp_valid)
   `ASSERT_NEXT(a_data_write_sends, clock, reset, data_write, tx_byte_sent)
   `ASSERT_NEXT(a_no_read_data, clock, reset, no_read, rsp_read_data == 8'h00)
   `ASSERT_NEXT(a_tx_irq_enable, clock, reset, tx_ie_write, rsp_irq)

endmodule

bind uart_rx_fifo_registers urf_checker u_urf_checker (.*);

// ===== sim/uart_rx_fifo_registers_tb.sv =====
// Self-checking testbench for the UART register block with its receive FIFO.
module uart_rx_fifo_registers_tb;
   import urf_pkg::*;

   // The block takes one beat per cycle once reset has gone. The result of a
   // beat accepted at one edge is shown in the next cycle, so a short wait at
   // the end is enough, and a stall that reaches STALL_LIMIT with nothing
   // moving can only mean the block has hung.
   localparam int          DEPTH          = 16;
   localparam int          RANDOM_BEATS   = 600;
   localparam int          IDLE_PERCENT   = 34;
   localparam int          STALL_LIMIT    = 2000;
   localparam int          DRAIN_CYCLES   = 4;
   localparam logic [1:0]  FUNC_NOP       = 2'd3;
   localparam logic [7:0]  OFFSET_UNUSED  = 8'd3;
   localparam logic [7:0]  OFFSET_TOP     = 8'hFF;

   // One result beat as it appears on the rsp_ ports.
   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       irq;
   } bus_result_type;

   // One row of the directed script. A row may repeat its beat several times,
   // with the received byte stepping up by one on each repeat. Where a row is
   // pinned, its result is typed in by hand instead of being predicted.
   typedef struct packed {
      logic [1:0]     func;
      logic [7:0]     offset;
      logic [7:0]     write_data;
      logic [7:0]     rx_byte;
      logic [4:0]     repeats;
      logic           pinned;
      bus_result_type pinned_result;
   } script_row_type;

   localparam int NUM_ROWS = 22;

   localparam script_row_type SCRIPT [NUM_ROWS] = '{
      // Straight after reset: status shows only the transmitter empty.
      '{FUNC_READ,    OFFSET_STATUS,  8'h00, 8'h00, 5'd1,  1'b1, '{8'h02, 1'b0, 8'h00, 1'b0}},
      // A read of the data register with nothing held returns zero.
      '{FUNC_READ,    OFFSET_DATA,    8'h00, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, 8'h00, 1'b0}},
      '{FUNC_READ,    OFFSET_CONTROL, 8'h00, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, 8'h00, 1'b0}},
      // Offsets with no register behind them read as zero.
      '{FUNC_READ,    OFFSET_TOP,     8'h00, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, 8'h00, 1'b0}},
      '{FUNC_READ,    OFFSET_UNUSED,  8'h00, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, 8'h00, 1'b0}},
      // Transmit writes at both extremes of the byte.
      '{FUNC_WRITE,   OFFSET_DATA,    8'hFF, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b1, 8'hFF, 1'b0}},
      '{FUNC_WRITE,   OFFSET_DATA,    8'h00, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b1, 8'h00, 1'b0}},
      // All control bits set: the transmit interrupt enable raises the line.
      '{FUNC_WRITE,   OFFSET_CONTROL, 8'hFF, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, 8'h00, 1'b1}},
      '{FUNC_READ,    OFFSET_CONTROL, 8'h00, 8'h00, 5'd1,  1'b1, '{8'hFF, 1'b0, 8'h00, 1'b1}},
      // A write to an unknown offset changes nothing.
      '{FUNC_WRITE,   OFFSET_TOP,     8'hAA, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, 8'h00, 1'b1}},
      // Receive interrupt only, with the FIFO empty: the line drops.
      '{FUNC_WRITE,   OFFSET_CONTROL, 8'h01, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, 8'h00, 1'b0}},
      '{FUNC_NOP,     OFFSET_DATA,    8'hFF, 8'hFF, 5'd1,  1'b1, '{8'h00, 1'b0, 8'h00, 1'b0}},
      // Fill the FIFO and push one byte more, which is dropped as an overrun.
      '{FUNC_RECEIVE, OFFSET_DATA,    8'h00, 8'hF0, 5'd17, 1'b0, '0},
      '{FUNC_READ,    OFFSET_STATUS,  8'h00, 8'h00, 5'd1,  1'b1, '{8'h07, 1'b0, 8'h00, 1'b1}},
      // Writing the status register clears the overrun, whatever the value.
      '{FUNC_WRITE,   OFFSET_STATUS,  8'hFF, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, 8'h00, 1'b1}},
      '{FUNC_READ,    OFFSET_STATUS,  8'h00, 8'h00, 5'd1,  1'b1, '{8'h03, 1'b0, 8'h00, 1'b1}},
      // Drain the whole FIFO, then read once more from the empty FIFO.
      '{FUNC_READ,    OFFSET_DATA,    8'h00, 8'h00, 5'd16, 1'b0, '0},
      '{FUNC_READ,    OFFSET_DATA,    8'h00, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, 8'h00, 1'b0}},
      '{FUNC_RECEIVE, OFFSET_TOP,     8'h00, 8'h00, 5'd1,  1'b0, '0},
      '{FUNC_NOP,     OFFSET_STATUS,  8'h00, 8'h00, 5'd1,  1'b0, '0},
      '{FUNC_READ,    OFFSET_DATA,    8'h00, 8'h00, 5'd1,  1'b0, '0},
      '{FUNC_WRITE,   OFFSET_CONTROL, 8'h00, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, 8'h00, 1'b0}}
   };

   // Every input holds a known value from time zero, and reset is high.
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        start          = 1'b0;
   logic [1:0]  req_func       = FUNC_NOP;
   logic [7:0]  req_offset     = '0;
   logic [7:0]  req_write_data = '0;
   logic [7:0]  req_rx_byte    = '0;
   logic        busy;
   logic        rsp_valid;
   logic [7:0]  rsp_read_data;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_irq;

   // Whether the beat on offer carries a hand-typed result, and that result.
   // These travel with the beat so that the monitor sees them at the same edge.
   logic           beat_pinned = 1'b0;
   bus_result_type beat_result = '0;

   // Shadow of the block's state, kept by the predictor.
   logic [7:0]  rx_fifo [$];
   logic        overrun_seen;
   logic [7:0]  control_shadow;

   bus_result_type pending_results [$];
   int             error_count    = 0;
   int             stall_cycles   = 0;
   int             idle_percent   = IDLE_PERCENT;

   always #2 clock = ~clock;

   uart_rx_fifo_registers #(
      .FIFO_DEPTH(DEPTH)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_offset    (req_offset),
      .req_write_data(req_write_data),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_read_data (rsp_read_data),
      .rsp_tx_valid  (rsp_tx_valid),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_irq       (rsp_irq)
   );

   // Works out the result of one beat and moves the shadow state on. The
   // interrupt level is taken after the beat has had its effect.
   function automatic bus_result_type predict_uart_access(input logic [1:0] func,
                                                          input logic [7:0] offset,
                                                          input logic [7:0] write_data,
                                                          input logic [7:0] rx_byte);
      bus_result_type result;
      result = '0;
      case (func)
         FUNC_READ: begin
            if (offset == OFFSET_DATA) begin
               if (rx_fifo.size() != 0) begin
                  result.read_data = rx_fifo.pop_front();
               end
            end else if (offset == OFFSET_STATUS) begin
               result.read_data = SR_TX_EMPTY;
               if (rx_fifo.size() != 0) begin
                  result.read_data = result.read_data | SR_RX_READY;
               end
               if (overrun_seen) begin
                  result.read_data = result.read_data | SR_OVERRUN;
               end
            end else if (offset == OFFSET_CONTROL) begin
               result.read_data = control_shadow;
            end
         end
         FUNC_WRITE: begin
            if (offset == OFFSET_DATA) begin
               result.tx_valid = 1'b1;
               result.tx_byte  = write_data;
            end else if (offset == OFFSET_STATUS) begin
               overrun_seen = 1'b0;
            end else if (offset == OFFSET_CONTROL) begin
               control_shadow = write_data;
            end
         end
         FUNC_RECEIVE: begin
            if (rx_fifo.size() >= DEPTH) begin
               overrun_seen = 1'b1;
            end else begin
               rx_fifo.push_back(rx_byte);
            end
         end
         default: begin
         end
      endcase
      result.irq = (((control_shadow & CR_RX_IE) != '0) && (rx_fifo.size() != 0))
                   || ((control_shadow & CR_TX_IE) != '0);
      return result;
   endfunction

   // Monitor. All signals are read at the rising edge, before anything that
   // changes at that edge has settled, so the values seen are those of the
   // cycle just ending. A beat offered while the block is not busy is taken
   // at this edge and its expectation joins the back of the queue; a strobed
   // result is compared with the oldest expectation waiting.
   always @(posedge clock) begin
      bus_result_type predicted;
      bus_result_type wanted;
      if (!reset) begin
         if (start && !busy) begin
            predicted = predict_uart_access(req_func, req_offset, req_write_data, req_rx_byte);
            pending_results.push_back(beat_pinned ? beat_result : predicted);
         end
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $error("result beat arrived with no beat outstanding");
               error_count++;
            end else begin
               wanted = pending_results.pop_front();
               if (rsp_read_data !== wanted.read_data) begin
                  $error("read_data: expected %02h, got %02h", wanted.read_data, rsp_read_data);
                  error_count++;
               end
               if (rsp_tx_valid !== wanted.tx_valid) begin
                  $error("tx_valid: expected %0b, got %0b", wanted.tx_valid, rsp_tx_valid);
                  error_count++;
               end
               if (rsp_tx_byte !== wanted.tx_byte) begin
                  $error("tx_byte: expected %02h, got %02h", wanted.tx_byte, rsp_tx_byte);
                  error_count++;
               end
               if (rsp_irq !== wanted.irq) begin
                  $error("irq: expected %0b, got %0b", wanted.irq, rsp_irq);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: counts cycles in which no beat moves on either side. A hung
   // block, or one that holds busy high for good, ends the run here.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offers one beat and waits until the block has taken it. Before the beat,
   // the sender may sit idle for some cycles, with start low and rubbish on
   // the request fields, which the block must ignore. Each signal is assigned
   // once per edge: an idle cycle always ends at a fresh edge before the beat
   // is put up, and back-to-back beats simply overwrite the fields.
   task automatic offer_beat(input logic [1:0] func, input logic [7:0] offset,
                             input logic [7:0] write_data, input logic [7:0] rx_byte,
                             input logic pinned, input bus_result_type pinned_result);
      while ($urandom_range(99) < idle_percent) begin
         start          <= 1'b0;
         req_func       <= 2'($urandom_range(3));
         req_offset     <= 8'($urandom_range(255));
         req_write_data <= 8'($urandom_range(255));
         req_rx_byte    <= 8'($urandom_range(255));
         @(posedge clock);
      end
      req_func       <= func;
      req_offset     <= offset;
      req_write_data <= write_data;
      req_rx_byte    <= rx_byte;
      beat_pinned    <= pinned;
      beat_result    <= pinned_result;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // Picks an offset: mostly the three registers, now and then any value at
   // all so that every offset bit toggles and unknown offsets are hit.
   function automatic logic [7:0] pick_offset(input int data_weight);
      int roll;
      roll = $urandom_range(99);
      if (roll < data_weight) begin
         return OFFSET_DATA;
      end else if (roll < data_weight + 15) begin
         return OFFSET_STATUS;
      end else if (roll < data_weight + 30) begin
         return OFFSET_CONTROL;
      end
      return 8'($urandom_range(255));
   endfunction

   initial begin
      logic [1:0] func;
      int         roll;
      bit         filling;

      rx_fifo.delete();
      overrun_seen   = 1'b0;
      control_shadow = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed script: the register map at its extremes, the interrupt
      // enables, a full FIFO with an overrun, and a complete drain.
      for (int row = 0; row < NUM_ROWS; row++) begin
         for (int rep = 0; rep < SCRIPT[row].repeats; rep++) begin
            offer_beat(SCRIPT[row].func, SCRIPT[row].offset, SCRIPT[row].write_data,
                       8'(SCRIPT[row].rx_byte + rep), SCRIPT[row].pinned,
                       SCRIPT[row].pinned_result);
         end
      end

      // Random beats. The mix swings between a filling spell, heavy on
      // received bytes so that the FIFO runs full and overruns, and a draining
      // spell, heavy on data reads so that it runs dry and reads come back
      // empty. One long stretch in the middle runs with no idle cycles.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         idle_percent = (n >= 250 && n < 400) ? 0 : IDLE_PERCENT;
         filling      = ((n / 60) % 2) == 0;
         roll         = $urandom_range(99);
         if (roll < 5) begin
            func = FUNC_NOP;
         end else if (roll < 25) begin
            func = FUNC_WRITE;
         end else if (roll < (filling ? 75 : 40)) begin
            func = FUNC_RECEIVE;
         end else begin
            func = FUNC_READ;
         end
         offer_beat(func, pick_offset(func == FUNC_READ && !filling ? 65 : 40),
                    8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, '0);
      end

      start <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
